### hdl/lrq_pkg.sv
// Shared types, sizes and codes for the request queue.
package lrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 4;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0]         func_t;
  typedef logic [14:0]        rtime_t;
  typedef logic [ID_BITS-1:0] rid_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_POP    = 2'd1;
  localparam func_t FN_PEEK   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t      func;
    rtime_t     req_stamp;
    logic [3:0] requester_id;
  } lrq_in_t;

  typedef struct packed {
    logic       head_valid;
    rtime_t     head_time;
    logic [3:0] head_id;
    logic [4:0] entry_count;
    logic [1:0] status;
  } lrq_out_t;

  typedef struct packed {
    rtime_t tm;
    rid_t   id;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;
    logic    wr_ins;
    logic    scan_init;
    logic    scan_run;
    logic    rd_last;
    logic    move_wr;
    logic    out_load;
    status_t status;
  } lrq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  scan_done;
  } lrq_stat_t;

endpackage

### hdl/lrq_ctrl.sv
// Operation sequencer for the request queue.
module lrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lrq_pkg::lrq_stat_t st,
  output lrq_pkg::lrq_cmd_t  cmd
);
  import lrq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_START,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  logic    moving_r, moving_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    moving_nxt    = moving_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.status    = status_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          status_nxt = ST_OK;
          moving_nxt = 1'b0;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.func == FN_INSERT) begin
          if (st.full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.wr_ins = 1'b1;
          end
        end else if (st.func == FN_POP) begin
          if (st.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            moving_nxt = 1'b1;
          end
        end
        state_nxt = S_SCAN_START;
      end
      S_SCAN_START: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          state_nxt = moving_r ? S_MOVE_RD : S_DONE;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // last entry fills the slot of the popped minimum
        cmd.move_wr = 1'b1;
        moving_nxt  = 1'b0;
        state_nxt   = S_SCAN_START;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      moving_r    <= 1'b0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      moving_r    <= moving_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/lrq_dp.sv
// Slot memory, fill count, minimum scan and result register.
module lrq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  lrq_pkg::lrq_in_t   in_data,
  input  lrq_pkg::lrq_cmd_t  cmd,
  output lrq_pkg::lrq_stat_t st,
  output lrq_pkg::lrq_out_t  out_data
);
  import lrq_pkg::*;

  slot_t    mem [QUEUE_DEPTH];
  lrq_in_t  in_r;
  cnt_t     count_r, count_nxt;
  cnt_t     scan_idx_r, scan_idx_nxt;
  logic     pend_r, pend_nxt;
  idx_t     pend_idx_r;
  slot_t    rdata_r;
  logic     best_valid_r, best_valid_nxt;
  slot_t    best_r, best_nxt;
  idx_t     best_idx_r, best_idx_nxt;
  lrq_out_t out_r;

  logic     issuing;
  idx_t     rd_addr;
  idx_t     last_idx;
  logic     we;
  idx_t     waddr;
  slot_t    wdata;
  logic     lower;

  assign last_idx = idx_t'(count_r - cnt_t'(1));
  assign issuing  = cmd.scan_run && (scan_idx_r < count_r);
  assign rd_addr  = cmd.rd_last ? last_idx : scan_idx_r[IDX_W-1:0];

  // strict compare: on a full tie the earlier slot keeps the lead
  assign lower = (rdata_r.tm < best_r.tm) ||
                 ((rdata_r.tm == best_r.tm) && (rdata_r.id < best_r.id));

  assign we    = cmd.wr_ins || cmd.move_wr;
  assign waddr = cmd.wr_ins ? count_r[IDX_W-1:0] : best_idx_r;
  always_comb begin
    if (cmd.wr_ins) begin
      wdata.tm = in_r.req_stamp;
      wdata.id = rid_t'(in_r.requester_id);
    end else begin
      wdata = rdata_r;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = issuing;
    best_valid_nxt = best_valid_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    if (cmd.wr_ins) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (cmd.move_wr) begin
      count_nxt = count_r - cnt_t'(1);
    end
    if (cmd.scan_init) begin
      scan_idx_nxt   = '0;
      best_valid_nxt = 1'b0;
    end else if (issuing) begin
      scan_idx_nxt = scan_idx_r + cnt_t'(1);
    end
    if (pend_r && (!best_valid_r || lower)) begin
      best_valid_nxt = 1'b1;
      best_nxt       = rdata_r;
      best_idx_nxt   = pend_idx_r;
    end
  end

  assign st.func      = in_r.func;
  assign st.full      = (count_r == cnt_t'(QUEUE_DEPTH));
  assign st.empty     = (count_r == '0);
  assign st.scan_done = cmd.scan_run && !issuing && !pend_r;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_r       <= 1'b0;
      best_valid_r <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      best_valid_r <= best_valid_nxt;
      scan_idx_r   <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    pend_idx_r <= scan_idx_r[IDX_W-1:0];
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (cmd.out_load) begin
      out_r.head_valid  <= best_valid_r;
      out_r.head_time   <= best_valid_r ? best_r.tm : '0;
      out_r.head_id     <= best_valid_r ? 4'(best_r.id) : 4'd0;
      out_r.entry_count <= 5'(count_r);
      out_r.status      <= cmd.status;
    end
  end

endmodule

### hdl/lamport_request_queue_core.sv
// Each operation ends with a scan of the table for its minimum; a pop on a non-empty table
// first scans, then moves the last entry into the popped slot and scans again. One slot
// read per cycle, one compare. One item at a time: the next is accepted in the cycle after
// the result loads, while the result waits in its register.
// Synchronous active-low reset empties the table at once.
module lamport_request_queue_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrq_pkg::lrq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lrq_pkg::lrq_out_t out_data
);
  import lrq_pkg::*;

  lrq_cmd_t  cmd;
  lrq_stat_t st;

  lrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lrq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule
